// ===== sv/pmm_pkg.sv =====
// Shared types and codes of the paged memory manager.
// Used by the top level, the page store and the port checker; depends on nothing.
package pmm_pkg;

   typedef logic [1:0] cmd_type;
   typedef logic [1:0] status_type;
   typedef logic [7:0] byte_type;

   // Command codes of a request.
   localparam cmd_type CMD_NEW   = 2'd0;
   localparam cmd_type CMD_KILL  = 2'd1;
   localparam cmd_type CMD_STORE = 2'd2;
   localparam cmd_type CMD_LOAD  = 2'd3;

   // Status codes of a response.
   localparam status_type STATUS_OK  = 2'd0;
   localparam status_type STATUS_OOM = 2'd1;
   localparam status_type STATUS_BAD = 2'd2;

   // Page number that stands for "no page", and the marks of a used and a free page.
   localparam byte_type NO_PAGE   = 8'hff;
   localparam byte_type PAGE_USED = 8'd1;
   localparam byte_type PAGE_FREE = 8'd0;

endpackage

// ===== sv/pmm_page_store.sv =====
// Byte memory of the paged memory manager with its clearing pass after reset.
// Single port, read data registered; depends on pmm_pkg.
module pmm_page_store #(
   parameter int MEM_BYTES = 16384
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         wr_en,
   input  logic [$clog2(MEM_BYTES)-1:0] addr,
   input  pmm_pkg::byte_type            wr_data,
   output pmm_pkg::byte_type            rd_data,
   output logic                         clear_busy
);
   import pmm_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);

   byte_type        mem [MEM_BYTES];
   byte_type        rd_data_ff;
   logic            busy_ff, busy_in;
   logic [AW-1:0]   clr_addr_ff, clr_addr_in;
   logic            port_we;
   logic [AW-1:0]   port_addr;
   byte_type        port_data;

   // The clearing pass owns the port until it has swept every byte.
   always_comb begin
      busy_in     = busy_ff;
      clr_addr_in = clr_addr_ff;
      if (busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MEM_BYTES - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         busy_ff     <= busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Byte 0 of the free map comes out of the pass marked used.
   assign port_we   = busy_ff | wr_en;
   assign port_addr = busy_ff ? clr_addr_ff : addr;
   assign port_data = busy_ff ? ((clr_addr_ff == '0) ? PAGE_USED : PAGE_FREE) : wr_data;

   // Memory array with a read-first registered port.
   always_ff @(posedge clock) begin
      if (port_we) begin
         mem[port_addr] <= port_data;
      end
      rd_data_ff <= mem[port_addr];
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = busy_ff;

endmodule

// ===== sv/paged_memory_manager.sv =====
// Paged memory manager: single-level page tables over one byte memory with a free map.
// Every free-map scan reads one byte a cycle through one port.
// One request at a time; the next request is taken once the response sits in its register.
// Reset is synchronous; afterwards a clearing pass over all PAGE_BYTES*PAGES bytes (16384
// at the defaults) holds off requests. PAGE_BYTES must be a power of two.
module paged_memory_manager #(
   parameter int PAGE_BYTES   = 256,
   parameter int PAGES        = 64,
   parameter int POINTER_BASE = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pmm_pkg::cmd_type    req_cmd,
   input  logic [5:0]          req_process_id,
   input  logic [13:0]         req_virt_address,
   input  logic [7:0]          req_store_data,
   input  logic [6:0]          req_page_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pmm_pkg::status_type rsp_status,
   output logic [13:0]         rsp_phys_address,
   output logic [7:0]          rsp_load_data,
   output logic [7:0]          rsp_table_page
);
   import pmm_pkg::*;

   localparam int MEM_BYTES = PAGE_BYTES * PAGES;
   localparam int AW        = $clog2(MEM_BYTES);
   localparam int OFF_W     = $clog2(PAGE_BYTES);
   localparam int ENTRIES   = (PAGES < PAGE_BYTES) ? PAGES : PAGE_BYTES;
   localparam int EW        = $clog2(ENTRIES + 1);
   localparam int SW        = $clog2(PAGES + 1);
   localparam int PTR_W     = $clog2(POINTER_BASE + 64);
   localparam int VW        = 14 - OFF_W;
   localparam logic [8:0] PAGES_9 = 9'(PAGES);

   // Sequencer states.
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SCAN     = 4'd1;
   localparam logic [3:0] S_GRAB_WR  = 4'd2;
   localparam logic [3:0] S_PTR_WR   = 4'd3;
   localparam logic [3:0] S_CLEAR    = 4'd4;
   localparam logic [3:0] S_ENTRY_WR = 4'd5;
   localparam logic [3:0] S_PTR_RD   = 4'd6;
   localparam logic [3:0] S_PTR_CHK  = 4'd7;
   localparam logic [3:0] S_KILL_RD  = 4'd8;
   localparam logic [3:0] S_KILL_CHK = 4'd9;
   localparam logic [3:0] S_KILL_TBL = 4'd10;
   localparam logic [3:0] S_KILL_PTR = 4'd11;
   localparam logic [3:0] S_XLT_CHK  = 4'd12;
   localparam logic [3:0] S_LD_WAIT  = 4'd13;
   localparam logic [3:0] S_FINISH   = 4'd14;

   logic [3:0]      state_ff, state_in;
   logic            data_phase_ff, data_phase_in;
   logic            chk_ff, chk_in;
   logic [SW-1:0]   scan_ff, scan_in;
   logic [EW-1:0]   idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;

   cmd_type         cmd_ff, cmd_in;
   logic [AW-1:0]   ptr_addr_ff, ptr_addr_in;
   logic            ptr_ok_ff, ptr_ok_in;
   logic [13:0]     va_ff, va_in;
   byte_type        sd_ff, sd_in;
   logic [EW-1:0]   cnt_ff, cnt_in;
   byte_type        grab_ff, grab_in;
   byte_type        table_ff, table_in;
   status_type      status_ff, status_in;
   logic [13:0]     phys_ff, phys_in;
   byte_type        ld_ff, ld_in;
   byte_type        tpage_ff, tpage_in;

   status_type      rsp_status_ff;
   logic [13:0]     rsp_phys_ff;
   byte_type        rsp_ld_ff;
   byte_type        rsp_tpage_ff;

   logic            mem_we;
   logic [AW-1:0]   store_addr;
   byte_type        mem_wdata;
   byte_type        mem_rdata;
   logic            clear_busy;

   logic            req_accept;
   logic            rsp_load;
   logic [PTR_W-1:0] ptr_full;
   byte_type        ptr_val;
   logic [VW-1:0]   vpage;
   logic [OFF_W-1:0] offset;
   logic [OFF_W-1:0] entry_off;
   logic [7+OFF_W:0] entry_addr;
   logic [7+OFF_W:0] xlt_addr;
   logic [7+OFF_W:0] byte_addr;
   byte_type        scan_page;

   pmm_page_store #(
      .MEM_BYTES (MEM_BYTES)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (mem_we),
      .addr       (store_addr),
      .wr_data    (mem_wdata),
      .rd_data    (mem_rdata),
      .clear_busy (clear_busy)
   );

   // Handshakes.
   assign req_stall  = (state_ff != S_IDLE) | clear_busy;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_load   = (state_ff == S_FINISH) & (~rsp_valid_ff | ~rsp_stall);

   // Address pieces.
   assign ptr_full   = PTR_W'(POINTER_BASE) + PTR_W'(req_process_id);
   assign ptr_val    = ptr_ok_ff ? mem_rdata : PAGE_FREE;
   assign vpage      = va_ff[13:OFF_W];
   assign offset     = va_ff[OFF_W-1:0];
   assign entry_off  = OFF_W'(idx_ff);
   assign entry_addr = {table_ff, entry_off};
   assign xlt_addr   = {ptr_val, OFF_W'(vpage)};
   assign byte_addr  = {mem_rdata, offset};
   assign scan_page  = 8'(scan_ff - SW'(1));

   // Sequencer: at most one memory access per cycle, read data back in the next cycle.
   always_comb begin
      state_in      = state_ff;
      data_phase_in = data_phase_ff;
      chk_in        = chk_ff;
      scan_in       = scan_ff;
      idx_in        = idx_ff;
      cmd_in        = cmd_ff;
      ptr_addr_in   = ptr_addr_ff;
      ptr_ok_in     = ptr_ok_ff;
      va_in         = va_ff;
      sd_in         = sd_ff;
      cnt_in        = cnt_ff;
      grab_in       = grab_ff;
      table_in      = table_ff;
      status_in     = status_ff;
      phys_in       = phys_ff;
      ld_in         = ld_ff;
      tpage_in      = tpage_ff;
      mem_we        = 1'b0;
      store_addr    = '0;
      mem_wdata     = PAGE_FREE;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               cmd_in        = req_cmd;
               ptr_addr_in   = AW'(ptr_full);
               ptr_ok_in     = 32'(ptr_full) < 32'(MEM_BYTES);
               va_in         = req_virt_address;
               sd_in         = req_store_data;
               cnt_in        = (32'(req_page_count) > 32'(ENTRIES)) ? EW'(ENTRIES)
                                                                    : EW'(req_page_count);
               status_in     = STATUS_OK;
               phys_in       = '0;
               ld_in         = '0;
               tpage_in      = NO_PAGE;
               data_phase_in = 1'b0;
               scan_in       = '0;
               chk_in        = 1'b0;
               state_in      = (req_cmd == CMD_NEW) ? S_SCAN : S_PTR_RD;
            end
         end

         // First-fit scan of the free map, one byte read per cycle.
         S_SCAN: begin
            if (chk_ff && (mem_rdata == PAGE_FREE)) begin
               grab_in  = scan_page;
               state_in = S_GRAB_WR;
            end else if (scan_ff == SW'(PAGES)) begin
               grab_in  = NO_PAGE;
               state_in = data_phase_ff ? S_ENTRY_WR : S_PTR_WR;
            end else begin
               store_addr = AW'(scan_ff);
               scan_in    = scan_ff + SW'(1);
               chk_in     = 1'b1;
            end
         end

         S_GRAB_WR: begin
            mem_we     = 1'b1;
            store_addr = AW'(grab_ff);
            mem_wdata  = PAGE_USED;
            state_in   = data_phase_ff ? S_ENTRY_WR : S_PTR_WR;
         end

         // Record the table page in the pointer byte.
         S_PTR_WR: begin
            mem_we     = ptr_ok_ff;
            store_addr = ptr_addr_ff;
            mem_wdata  = grab_ff;
            tpage_in   = grab_ff;
            table_in   = grab_ff;
            idx_in     = '0;
            if (grab_ff == NO_PAGE) begin
               status_in = STATUS_OOM;
               state_in  = S_FINISH;
            end else begin
               state_in = S_CLEAR;
            end
         end

         // Wipe the entries of the fresh table page.
         S_CLEAR: begin
            mem_we     = 1'b1;
            store_addr = AW'(entry_addr);
            mem_wdata  = PAGE_FREE;
            idx_in     = idx_ff + EW'(1);
            if (idx_ff == EW'(ENTRIES - 1)) begin
               idx_in        = '0;
               data_phase_in = 1'b1;
               scan_in       = '0;
               chk_in        = 1'b0;
               state_in      = (cnt_ff == '0) ? S_FINISH : S_SCAN;
            end
         end

         // Write one data page mapping, then scan for the next one or finish.
         S_ENTRY_WR: begin
            mem_we     = 1'b1;
            store_addr = AW'(entry_addr);
            mem_wdata  = grab_ff;
            if (grab_ff == NO_PAGE) begin
               status_in = STATUS_OOM;
            end
            idx_in  = idx_ff + EW'(1);
            scan_in = '0;
            chk_in  = 1'b0;
            state_in = (idx_ff == cnt_ff - EW'(1)) ? S_FINISH : S_SCAN;
         end

         S_PTR_RD: begin
            store_addr = ptr_addr_ff;
            state_in   = S_PTR_CHK;
         end

         // The pointer byte is here: kill or translate.
         S_PTR_CHK: begin
            table_in = ptr_val;
            idx_in   = '0;
            if (cmd_ff == CMD_KILL) begin
               if ({1'b0, ptr_val} >= PAGES_9) begin
                  status_in = STATUS_BAD;
                  state_in  = S_FINISH;
               end else if (ptr_val == PAGE_FREE) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_KILL_RD;
               end
            end else if (({1'b0, ptr_val} >= PAGES_9) || (32'(vpage) >= 32'(ENTRIES))) begin
               status_in = STATUS_BAD;
               state_in  = S_FINISH;
            end else begin
               store_addr = AW'(xlt_addr);
               state_in   = S_XLT_CHK;
            end
         end

         S_KILL_RD: begin
            store_addr = AW'(entry_addr);
            state_in   = S_KILL_CHK;
         end

         // Free the data page of one table entry.
         S_KILL_CHK: begin
            if ((mem_rdata != PAGE_FREE) && ({1'b0, mem_rdata} < PAGES_9)) begin
               mem_we     = 1'b1;
               store_addr = AW'(mem_rdata);
               mem_wdata  = PAGE_FREE;
            end
            idx_in   = idx_ff + EW'(1);
            state_in = (idx_ff == EW'(ENTRIES - 1)) ? S_KILL_TBL : S_KILL_RD;
         end

         S_KILL_TBL: begin
            mem_we     = 1'b1;
            store_addr = AW'(table_ff);
            mem_wdata  = PAGE_FREE;
            state_in   = S_KILL_PTR;
         end

         S_KILL_PTR: begin
            mem_we     = ptr_ok_ff;
            store_addr = ptr_addr_ff;
            mem_wdata  = PAGE_FREE;
            state_in   = S_FINISH;
         end

         // The table entry is here: check it and do the access.
         S_XLT_CHK: begin
            if ({1'b0, mem_rdata} >= PAGES_9) begin
               status_in = STATUS_BAD;
               state_in  = S_FINISH;
            end else begin
               phys_in    = 14'(byte_addr);
               store_addr = AW'(byte_addr);
               if (cmd_ff == CMD_STORE) begin
                  mem_we    = 1'b1;
                  mem_wdata = sd_ff;
                  state_in  = S_FINISH;
               end else begin
                  state_in = S_LD_WAIT;
               end
            end
         end

         S_LD_WAIT: begin
            ld_in    = mem_rdata;
            state_in = S_FINISH;
         end

         S_FINISH: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         data_phase_ff <= 1'b0;
         chk_ff        <= 1'b0;
         scan_ff       <= '0;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         data_phase_ff <= data_phase_in;
         chk_ff        <= chk_in;
         scan_ff       <= scan_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Request and working payload registers.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      ptr_addr_ff <= ptr_addr_in;
      ptr_ok_ff   <= ptr_ok_in;
      va_ff       <= va_in;
      sd_ff       <= sd_in;
      cnt_ff      <= cnt_in;
      grab_ff     <= grab_in;
      table_ff    <= table_in;
      status_ff   <= status_in;
      phys_ff     <= phys_in;
      ld_ff       <= ld_in;
      tpage_ff    <= tpage_in;
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_phys_ff   <= phys_ff;
         rsp_ld_ff     <= ld_ff;
         rsp_tpage_ff  <= tpage_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_phys_address = rsp_phys_ff;
   assign rsp_load_data    = rsp_ld_ff;
   assign rsp_table_page   = rsp_tpage_ff;

endmodule

// ===== sv/pmm_checker.sv =====
// Port checker of the paged memory manager, bound to the top level.
// Sees the top level's ports only; depends on pmm_pkg.
module pmm_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input pmm_pkg::status_type rsp_status,
   input logic [13:0]         rsp_phys_address,
   input logic [7:0]          rsp_load_data,
   input logic [7:0]          rsp_table_page
);
   import pmm_pkg::*;

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_phys_address) && $stable(rsp_load_data) && $stable(rsp_table_page))
      else $error("stalled response changed");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // A failed command reports no address and no data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_BAD || rsp_status == STATUS_OOM)
         |-> rsp_phys_address == 14'd0 && rsp_load_data == 8'd0)
      else $error("failed command shows an address or data");

   // Out of memory only comes from a new process, which never shows an address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_page != NO_PAGE |-> rsp_phys_address == 14'd0
         && rsp_load_data == 8'd0 && rsp_status != STATUS_BAD)
      else $error("new process response carries access fields");

endmodule

bind paged_memory_manager pmm_checker u_pmm_checker (.*);

// ===== test/tb_paged_memory_manager.sv =====
// Self-checking testbench of the paged memory manager: directed and random requests
// on the valid/stall channels, predicted against a behavioral page memory.
// Depends on pmm_pkg and paged_memory_manager from the RTL.
module tb_paged_memory_manager;
   import pmm_pkg::*;

   localparam int PAGE_BYTES     = 256;
   localparam int PAGES          = 64;
   localparam int POINTER_BASE   = 64;
   localparam int TABLE_ENTRIES  = (PAGES < PAGE_BYTES) ? PAGES : PAGE_BYTES;
   localparam int MEM_BYTES      = PAGE_BYTES * PAGES;
   localparam int POOL_PIDS      = 12;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 200;
   localparam int WATCHDOG_LIMIT = 100000;

   typedef struct packed {
      cmd_type     cmd;
      status_type  status;
      logic [13:0] phys_address;
      byte_type    load_data;
      byte_type    table_page;
   } response_type;

   // Behavioral page memory: predicts every response and checks the block against it.
   class page_table_tracker;
      byte_type     page_mem [MEM_BYTES];
      response_type expected_q [$];
      int           mismatch_count;

      function new();
         foreach (page_mem[i]) page_mem[i] = PAGE_FREE;
         page_mem[0] = PAGE_USED;
         mismatch_count = 0;
      endfunction

      // First-fit search of the free map; marks the page used.
      function int unsigned grab_page();
         for (int p = 0; p < PAGES; p++) begin
            if (page_mem[p] == PAGE_FREE) begin
               page_mem[p] = PAGE_USED;
               return p;
            end
         end
         return NO_PAGE;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      // Applies an accepted request to the memory and queues the response it must give.
      function void note_request(cmd_type cmd, logic [5:0] pid, logic [13:0] va,
                                 byte_type sd, logic [6:0] cnt);
         int unsigned  ptr_addr, t, base, d, vpage, off, pp, a, n;
         response_type r;
         ptr_addr = POINTER_BASE + pid;
         r.cmd = cmd;
         r.status = STATUS_OK;
         r.phys_address = '0;
         r.load_data = '0;
         r.table_page = NO_PAGE;
         case (cmd)
            CMD_NEW: begin
               t = grab_page();
               page_mem[ptr_addr] = byte_type'(t);
               r.table_page = byte_type'(t);
               if (t == NO_PAGE) begin
                  r.status = STATUS_OOM;
               end else begin
                  base = t * PAGE_BYTES;
                  n = (cnt > TABLE_ENTRIES) ? TABLE_ENTRIES : cnt;
                  // A fresh table page never keeps stale mappings.
                  for (int i = 0; i < TABLE_ENTRIES; i++) page_mem[base + i] = '0;
                  for (int i = 0; i < n; i++) begin
                     d = grab_page();
                     if (d == NO_PAGE) r.status = STATUS_OOM;
                     page_mem[base + i] = byte_type'(d);
                  end
               end
            end
            CMD_KILL: begin
               t = page_mem[ptr_addr];
               if (t >= PAGES) begin
                  r.status = STATUS_BAD;
               end else if (t != 0) begin
                  base = t * PAGE_BYTES;
                  for (int i = 0; i < TABLE_ENTRIES; i++) begin
                     d = page_mem[base + i];
                     if (d != 0 && d < PAGES) page_mem[d] = PAGE_FREE;
                  end
                  page_mem[t] = PAGE_FREE;
                  page_mem[ptr_addr] = '0;
               end
            end
            default: begin
               t = page_mem[ptr_addr];
               vpage = va / PAGE_BYTES;
               off = va % PAGE_BYTES;
               if (t >= PAGES || vpage >= TABLE_ENTRIES) begin
                  r.status = STATUS_BAD;
               end else begin
                  pp = page_mem[t * PAGE_BYTES + vpage];
                  if (pp >= PAGES) begin
                     r.status = STATUS_BAD;
                  end else begin
                     a = pp * PAGE_BYTES + off;
                     r.phys_address = a[13:0];
                     if (cmd == CMD_STORE) page_mem[a] = sd;
                     else r.load_data = page_mem[a];
                  end
               end
            end
         endcase
         expected_q.push_back(r);
      endfunction

      // Compares one accepted response with the oldest prediction.
      function void check_response(status_type st, logic [13:0] pa, byte_type ld,
                                   byte_type tp);
         response_type e;
         if (expected_q.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected response: status %0d phys %0h load %0h table %0h",
                        st, pa, ld, tp);
            mismatch_count++;
            return;
         end
         e = expected_q.pop_front();
         if (st !== e.status || pa !== e.phys_address || ld !== e.load_data ||
             tp !== e.table_page) begin
            if (mismatch_count < 10) begin
               $display("mismatch on cmd %0d (expected/actual): status %0d/%0d phys %0h/%0h",
                        e.cmd, e.status, st, e.phys_address, pa);
               $display("   load %0h/%0h table %0h/%0h",
                        e.load_data, ld, e.table_page, tp);
            end
            mismatch_count++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   cmd_type     req_cmd;
   logic [5:0]  req_process_id;
   logic [13:0] req_virt_address;
   logic [7:0]  req_store_data;
   logic [6:0]  req_page_count;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   status_type  rsp_status;
   logic [13:0] rsp_phys_address;
   logic [7:0]  rsp_load_data;
   logic [7:0]  rsp_table_page;

   page_table_tracker board;
   int unsigned send_idle_pct;
   int unsigned recv_idle_pct;
   bit          hold_pending = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   // The stimulus keeps its own rough view of which pool processes live.
   bit          alive [64];
   int unsigned mapped_pages [64];

   paged_memory_manager u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_process_id   (req_process_id),
      .req_virt_address (req_virt_address),
      .req_store_data   (req_store_data),
      .req_page_count   (req_page_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_phys_address (rsp_phys_address),
      .rsp_load_data    (rsp_load_data),
      .rsp_table_page   (rsp_table_page)
   );

   always #2 clock = ~clock;

   // Offers one request, with random idle cycles ahead of it, until the block takes it.
   task automatic send_request(cmd_type cmd, logic [5:0] pid, logic [13:0] va,
                               byte_type sd, logic [6:0] cnt);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < send_idle_pct) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_process_id   <= pid;
      req_virt_address <= va;
      req_store_data   <= sd;
      req_page_count   <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(cmd, pid, va, sd, cnt);
      if (cmd == CMD_NEW) begin
         alive[pid] = 1'b1;
         mapped_pages[pid] = (cnt > TABLE_ENTRIES) ? TABLE_ENTRIES : cnt;
      end else if (cmd == CMD_KILL) begin
         alive[pid] = 1'b0;
         mapped_pages[pid] = 0;
      end
   endtask

   // Whether a pool process suits a command in a well-formed sequence.
   function automatic bit pid_fits(cmd_type cmd, int unsigned pid);
      case (cmd)
         CMD_NEW:  return !alive[pid];
         CMD_KILL: return alive[pid];
         default:  return alive[pid] && mapped_pages[pid] > 0;
      endcase
   endfunction

   // Mostly well-formed process lifecycles over a small pool, the rest pure noise.
   task automatic send_random_request();
      int unsigned pick, pid, cnt, va, tries;
      cmd_type     cmd;
      if ($urandom_range(0, 99) < 15) begin
         send_request(cmd_type'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
                      14'($urandom_range(0, 16383)), 8'($urandom_range(0, 255)),
                      7'($urandom_range(0, 127)));
         return;
      end
      pick = $urandom_range(0, 99);
      if (pick < 14) cmd = CMD_NEW;
      else if (pick < 26) cmd = CMD_KILL;
      else if (pick < 63) cmd = CMD_STORE;
      else cmd = CMD_LOAD;
      pid = $urandom_range(0, POOL_PIDS - 1);
      for (tries = 0; tries < 20 && !pid_fits(cmd, pid); tries++)
         pid = $urandom_range(0, POOL_PIDS - 1);
      if (!pid_fits(cmd, pid)) cmd = alive[pid] ? CMD_KILL : CMD_NEW;
      // Small page counts dominate so that allocation scans stay short.
      pick = $urandom_range(0, 99);
      if (pick < 80) cnt = $urandom_range(0, 4);
      else if (pick < 92) cnt = $urandom_range(5, 16);
      else if (pick < 98) cnt = $urandom_range(17, 64);
      else cnt = $urandom_range(65, 127);
      if ((cmd == CMD_STORE || cmd == CMD_LOAD) && mapped_pages[pid] > 0)
         va = $urandom_range(0, mapped_pages[pid] - 1) * PAGE_BYTES +
              $urandom_range(0, PAGE_BYTES - 1);
      else
         va = $urandom_range(0, 16383);
      send_request(cmd, 6'(pid), 14'(va), 8'($urandom_range(0, 255)), 7'(cnt));
   endtask

   // Response side: checks accepted responses and drives stall, with one long hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_response(rsp_status, rsp_phys_address, rsp_load_data, rsp_table_page);
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_pending && !hold_done) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Watchdog: ends the run when no request and no response moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Main sequence: reset, directed requests, three random phases, drain and verdict.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_NEW;
      req_process_id = '0;
      req_virt_address = '0;
      req_store_data = '0;
      req_page_count = '0;
      send_idle_pct = 14;
      recv_idle_pct = 78;
      foreach (alive[i]) begin
         alive[i] = 1'b0;
         mapped_pages[i] = 0;
      end
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Basic mapping: store and load at both ends of mapped pages and data values.
      send_request(CMD_NEW,   6'd0,  14'h0000, 8'h00, 7'd3);
      send_request(CMD_STORE, 6'd0,  14'h0000, 8'hff, 7'd0);
      send_request(CMD_STORE, 6'd0,  14'h02ff, 8'h00, 7'd0);
      send_request(CMD_LOAD,  6'd0,  14'h0000, 8'h00, 7'd0);
      send_request(CMD_LOAD,  6'd0,  14'h02ff, 8'h00, 7'd0);
      // Unmapped entries read as page zero.
      send_request(CMD_LOAD,  6'd0,  14'h0300, 8'h00, 7'd0);
      send_request(CMD_LOAD,  6'd0,  14'h3fff, 8'h00, 7'd0);
      send_request(CMD_NEW,   6'd63, 14'h0000, 8'h00, 7'd0);
      send_request(CMD_LOAD,  6'd63, 14'h0010, 8'h00, 7'd0);
      // Oversized page count saturates and runs out of data pages.
      send_request(CMD_NEW,   6'd1,  14'h0000, 8'h00, 7'd127);
      // No table page left: the pointer becomes the no-page mark.
      send_request(CMD_NEW,   6'd2,  14'h0000, 8'h00, 7'd64);
      send_request(CMD_KILL,  6'd2,  14'h0000, 8'h00, 7'd0);
      send_request(CMD_LOAD,  6'd2,  14'h0000, 8'h00, 7'd0);
      send_request(CMD_STORE, 6'd2,  14'h0000, 8'h5a, 7'd0);
      // Kill skips no-page entries; a second kill finds a cleared pointer.
      send_request(CMD_KILL,  6'd1,  14'h0000, 8'h00, 7'd0);
      send_request(CMD_KILL,  6'd1,  14'h0000, 8'h00, 7'd0);
      send_request(CMD_KILL,  6'd63, 14'h0000, 8'h00, 7'd0);
      send_request(CMD_KILL,  6'd0,  14'h0000, 8'h00, 7'd0);
      send_request(CMD_LOAD,  6'd5,  14'h0140, 8'h00, 7'd0);
      // A reused table page with stale entries, filled up to the last free page.
      send_request(CMD_NEW,   6'd3,  14'h0000, 8'h00, 7'd64);
      send_request(CMD_STORE, 6'd3,  14'h3d07, 8'ha5, 7'd0);
      send_request(CMD_LOAD,  6'd3,  14'h3d07, 8'h00, 7'd0);
      send_request(CMD_LOAD,  6'd3,  14'h3e00, 8'h00, 7'd0);
      send_request(CMD_KILL,  6'd3,  14'h0000, 8'h00, 7'd0);
      send_request(CMD_NEW,   6'd2,  14'h0000, 8'h00, 7'd1);

      repeat (280) send_random_request();
      send_idle_pct = 78;
      recv_idle_pct = 14;
      repeat (280) send_random_request();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_pending = 1'b1;
      repeat (290) send_random_request();
      req_valid <= 1'b0;

      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (board.mismatch_count == 0 && board.outstanding() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== paged_memory_manager.f =====
sv/pmm_pkg.sv
sv/pmm_page_store.sv
sv/paged_memory_manager.sv
sv/pmm_checker.sv
test/tb_paged_memory_manager.sv
